// ===== hw/rtl/mdrc_pkg.sv =====
// Shared types, constants and helpers for the motor drive ramp controller.
// No dependencies; every other file imports this package.
package mdrc_pkg;

  localparam int DUTY_W     = 8;
  localparam int SPEED_W    = 16;
  localparam int DUR_W      = 16;
  localparam int CFG_W      = 8;
  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = 5;

  localparam logic [DUTY_W-1:0] DUTY_MAX          = 8'd255;
  localparam logic [CFG_W-1:0]  STEP_PERIOD_RESET = 8'd10;

  typedef enum logic [1:0] {
    OP_SET_SPEED = 2'd0,
    OP_SET_DIR   = 2'd1,
    OP_RAMP      = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_REV   = 2'd1,
    DIR_BRAKE = 2'd2,
    DIR_COAST = 2'd3
  } dir_t;

  typedef enum logic {
    REG_STEP_PERIOD = 1'b0,
    REG_ALARM_CONN  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [SPEED_W-1:0]  speed_value;
    dir_t                       direction;
    logic [DUTY_W-1:0]          ramp_target;
    logic [DUR_W-1:0]           ramp_duration;
    logic                       alarm_level;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              forward_line;
    logic              enable_line;
    logic              brake_line;
    logic              ramp_busy;
    logic              fault;
  } out_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic exec;      // apply the command's immediate updates
    logic mul_load;  // register the ramp product
    logic div_go;    // launch the shared divider
    logic div_apply; // use the quotient
    logic out_load;  // load the result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_steps_div;  // ramp start needs duration / period
    logic need_step_value; // tick ends a step inside the ramp
    logic div_done;
    logic out_free;
  } status_t;

  // Saturate a signed speed request to the duty range.
  function automatic logic [DUTY_W-1:0] clamp_speed(input logic signed [SPEED_W-1:0] v);
    logic [DUTY_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(SPEED_W-DUTY_W){1'b0}}, DUTY_MAX})) begin
      res = DUTY_MAX;
    end else begin
      res = v[DUTY_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/mdrc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by ramp start and ramp steps.
// Depends on mdrc_pkg.
module mdrc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mdrc_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [mdrc_pkg::DIVISOR_W-1:0]    divisor,
  output logic                              done,
  output logic [mdrc_pkg::DIVIDEND_W-1:0]   quotient,
  output logic [mdrc_pkg::DIVISOR_W-1:0]    remainder
);
  import mdrc_pkg::*;

  logic                    busy;
  logic [DIV_CNT_W-1:0]    cnt;
  logic [DIVISOR_W-1:0]    rem;
  logic [DIVIDEND_W-1:0]   quo;
  logic [DIVISOR_W+1:0]    trial;
  logic                    fits;
  logic [DIVISOR_W-1:0]    rem_next;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial    = {1'b0, rem, quo[DIVIDEND_W-1]} - {2'b00, divisor};
    fits     = !trial[DIVISOR_W+1];
    rem_next = fits ? trial[DIVISOR_W-1:0] : {rem[DIVISOR_W-2:0], quo[DIVIDEND_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIVIDEND_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hw/rtl/mdrc_datapath.sv =====
// Datapath: config registers, motor line state, ramp state, product and result register.
// Depends on mdrc_pkg and mdrc_div.
module mdrc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mdrc_pkg::in_t                 in_data,
  input  logic                          cfg_write_en,
  input  logic                          cfg_index,
  input  logic [mdrc_pkg::CFG_W-1:0]    cfg_data,
  input  mdrc_pkg::cmd_t                cmd,
  output mdrc_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mdrc_pkg::out_t                out_data
);
  import mdrc_pkg::*;

  // Held transaction and configuration
  in_t                 item;
  logic [CFG_W-1:0]    period;
  logic                alarm_conn;

  // Motor and ramp state
  logic [DUTY_W-1:0]   duty;
  logic                fwd;
  logic                en;
  logic                brk;
  logic                active;
  logic [DUTY_W-1:0]   ramp_start;
  logic [DUTY_W-1:0]   ramp_goal;
  logic [DUR_W-1:0]    steps;
  logic [DUR_W-1:0]    idx;
  logic [CFG_W-1:0]    ms;

  // Product register
  logic [DIVIDEND_W-1:0] prod_mag;
  logic                  prod_neg;

  logic [CFG_W-1:0]       ms_inc;
  logic [DUR_W-1:0]       idx_inc;
  logic                   step_end;
  logic                   last_step;
  logic signed [DUTY_W:0] diff;
  logic signed [DUTY_W+DUR_W+1:0] prod_full;
  logic [DUTY_W+DUR_W+1:0]        prod_abs;
  logic [DIVIDEND_W-1:0]  div_a;
  logic [DIVISOR_W-1:0]   div_b;
  logic                   div_done;
  logic [DIVIDEND_W-1:0]  div_q;
  logic [DIVISOR_W-1:0]   div_r;
  logic [DUTY_W-1:0]      q8;
  logic [DUTY_W-1:0]      q_adj;
  logic [DUTY_W-1:0]      step_duty;
  logic                   is_ramp;

  // Tick bookkeeping
  always_comb begin
    ms_inc    = ms + 1'b1;
    idx_inc   = idx + 1'b1;
    step_end  = (ms_inc >= period);
    last_step = (idx_inc >= steps);
    is_ramp   = (item.operation == OP_RAMP);
  end

  // Signed product of (goal - start) and the step index
  always_comb begin
    diff      = $signed({1'b0, ramp_goal}) - $signed({1'b0, ramp_start});
    prod_full = diff * $signed({1'b0, idx});
    prod_abs  = prod_full[DUTY_W+DUR_W+1] ? (DUTY_W+DUR_W+2)'(-prod_full) : prod_full;
  end

  // Divider operands: steps = duration / period, or |product| / steps
  always_comb begin
    div_a = is_ramp ? {{(DIVIDEND_W-DUR_W){1'b0}}, item.ramp_duration} : prod_mag;
    div_b = is_ramp ? {{(DIVISOR_W-CFG_W){1'b0}}, period} : steps;
  end

  mdrc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Floor division result for a negative product rounds away from zero
  always_comb begin
    q8        = div_q[DUTY_W-1:0];
    q_adj     = prod_neg ? (DUTY_W'(0) - (q8 + {{(DUTY_W-1){1'b0}}, (div_r != '0)})) : q8;
    step_duty = ramp_start + q_adj;
  end

  // Status to the controller
  always_comb begin
    status.need_steps_div  = is_ramp && (period != '0) && (item.ramp_duration != '0);
    status.need_step_value = (item.operation == OP_TICK) && active && step_end && !last_step;
    status.div_done        = div_done;
    status.out_free        = !out_valid || out_ready;
  end

  // Transaction capture and product register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.mul_load) begin
      prod_mag <= prod_abs[DIVIDEND_W-1:0];
      prod_neg <= prod_full[DUTY_W+DUR_W+1];
    end
  end

  // Config and motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= STEP_PERIOD_RESET;
      alarm_conn <= 1'b0;
      duty       <= '0;
      fwd        <= 1'b0;
      en         <= 1'b0;
      brk        <= 1'b1;
      active     <= 1'b0;
      ramp_start <= '0;
      ramp_goal  <= '0;
      steps      <= '0;
      idx        <= '0;
      ms         <= '0;
    end else begin
      if (cfg_write_en) begin
        case (reg_idx_t'(cfg_index))
          REG_STEP_PERIOD: period     <= cfg_data;
          REG_ALARM_CONN:  alarm_conn <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.exec) begin
        case (item.operation)
          OP_SET_SPEED: begin
            active <= 1'b0;
            duty   <= clamp_speed(item.speed_value);
          end
          OP_SET_DIR: begin
            active <= 1'b0;
            if (!item.speed_value[SPEED_W-1]) begin
              duty <= clamp_speed(item.speed_value);
            end
            case (item.direction)
              DIR_FWD: begin
                fwd <= 1'b1;
                en  <= 1'b1;
                brk <= 1'b0;
              end
              DIR_REV: begin
                fwd <= 1'b0;
                en  <= 1'b1;
                brk <= 1'b0;
              end
              DIR_BRAKE: begin
                en   <= 1'b0;
                brk  <= 1'b1;
                duty <= '0;
              end
              DIR_COAST: begin
                en   <= 1'b0;
                brk  <= 1'b0;
                duty <= '0;
              end
              default: ;
            endcase
          end
          OP_RAMP: begin
            active <= 1'b0;
            if ((period == '0) || (item.ramp_duration == '0)) begin
              duty <= item.ramp_target;
            end
          end
          OP_TICK: begin
            if (active) begin
              if (step_end) begin
                ms  <= '0;
                idx <= idx_inc;
                if (last_step) begin
                  duty   <= ramp_goal;
                  active <= 1'b0;
                end
              end else begin
                ms <= ms_inc;
              end
            end
          end
          default: ;
        endcase
      end

      // Quotient ready: ramp setup or new step duty
      if (cmd.div_apply) begin
        if (is_ramp) begin
          if (div_q[DUR_W-1:0] == '0) begin
            duty <= item.ramp_target;
          end else begin
            ramp_start <= duty;
            ramp_goal  <= item.ramp_target;
            steps      <= div_q[DUR_W-1:0];
            idx        <= '0;
            ms         <= '0;
            active     <= 1'b1;
          end
        end else begin
          duty <= step_duty;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.duty         <= duty;
      out_data.forward_line <= fwd;
      out_data.enable_line  <= en;
      out_data.brake_line   <= brk;
      out_data.ramp_busy    <= active;
      out_data.fault        <= alarm_conn && !item.alarm_level;
    end
  end

endmodule

// ===== hw/rtl/mdrc_ctrl.sv =====
// Controller state machine: sequences capture, execute, multiply, divide and result load.
// Depends on mdrc_pkg.
module mdrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mdrc_pkg::status_t   status,
  output mdrc_pkg::cmd_t      cmd
);
  import mdrc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.need_steps_div) begin
          state_next = ST_DIV_WAIT;
        end else if (status.need_step_value) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_MUL:      state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        cmd.div_go = status.need_steps_div;
      end
      ST_MUL:      cmd.mul_load  = 1'b1;
      ST_DIV_GO:   cmd.div_go    = 1'b1;
      ST_DIV_WAIT: cmd.div_apply = status.div_done;
      ST_FIN:      cmd.out_load  = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/motor_drive_ramp_controller.sv =====
// Top level of the motor drive ramp controller: controller plus datapath.
// Depends on mdrc_pkg, mdrc_ctrl, mdrc_datapath (and mdrc_div below it).
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------
//  in      | in_valid / in_ready        | in_data  (mdrc_pkg::in_t)
//  out     | out_valid / out_ready      | out_data (mdrc_pkg::out_t)
//  cfg     | cfg_write_en (no wait)     | cfg_index, cfg_data
//
// One transaction at a time, one result each. Divides run on the shared 24-iteration
// restoring divider. States: set speed, set direction, ticks that close no inner step:
// execute, result load. Ramp start: execute, divide, load (no divide if duration or
// period is zero). Tick closing an inner ramp step: execute, multiply, divide, load.
// Synchronous reset puts the lines at brake, duty 0, no ramp, step period 10.
// A stalled result holds in the output register; the next transaction is taken meanwhile.
module motor_drive_ramp_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mdrc_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mdrc_pkg::out_t                out_data,
  input  logic                          cfg_write_en,
  input  logic                          cfg_index,
  input  logic [mdrc_pkg::CFG_W-1:0]    cfg_data
);
  import mdrc_pkg::*;

  cmd_t    cmd;
  status_t status;

  mdrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mdrc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_data      (in_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ===== hw/rtl/mdrc_chk.sv =====
// Port-level checker for the motor drive ramp controller, bound to the top level.
// Depends on mdrc_pkg.
module mdrc_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  mdrc_pkg::out_t                out_data
);
  import mdrc_pkg::*;

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // One transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // Brake and enable are never driven together
  a_brake_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.brake_line && out_data.enable_line))
    else $error("brake and enable both high");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind motor_drive_ramp_controller mdrc_chk u_mdrc_chk (.*);

// ===== dv/motor_drive_ramp_controller_tb.sv =====
// Self-checking testbench for motor_drive_ramp_controller: directed table, then random commands.
// Depends on mdrc_pkg and the RTL; a local drive-state model predicts every result the directed table does not give.
`timescale 1ns / 100ps

module motor_drive_ramp_controller_tb;
  import mdrc_pkg::*;

  localparam int ITEMS_GOAL = 1900;

  typedef struct {
    bit         is_cfg;
    logic [7:0] period;
    logic       alarm_wired;
    in_t        item;
    int         reps;
    bit         has_res;
    out_t       res;
  } test_row_t;

  logic           clk;
  logic           rst          = 1'b1;
  logic           in_valid     = 1'b0;
  logic           in_ready;
  in_t            in_data      = '0;
  logic           out_valid;
  logic           out_ready    = 1'b0;
  out_t           out_data;
  logic           cfg_write_en = 1'b0;
  logic           cfg_index    = 1'b0;
  logic [CFG_W-1:0] cfg_data   = '0;

  // Drive-state model and its copy of the settings
  logic [7:0]  drive_duty;
  logic        drive_fwd;
  logic        drive_en;
  logic        drive_brake;
  logic        ramp_on;
  logic [7:0]  ramp_from;
  logic [7:0]  ramp_to;
  logic [15:0] ramp_len;
  logic [15:0] ramp_pos;
  logic [7:0]  ms_count;
  logic [7:0]  cfg_period;
  logic        cfg_wired;

  out_t expected_lines[$];
  int   error_count  = 0;
  int   sent_items   = 0;
  int   phase_end    = 0;
  int   calm_items   = 0;
  bit   rx_hold_req  = 0;

  motor_drive_ramp_controller i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("motor_drive_ramp_controller_tb: FAIL");
    $finish;
  end

  function automatic logic [7:0] saturate_speed(input logic signed [15:0] s);
    if (s < 0) return 8'd0;
    if (s > 16'sd255) return 8'd255;
    return s[7:0];
  endfunction

  // Advance the drive state by one command and return the lines it leaves.
  function automatic out_t apply_command(input in_t c);
    out_t       r;
    logic [15:0] nsteps;
    int         diff;
    int         prod;
    int         q;
    int         den;
    case (c.operation)
      OP_SET_SPEED: begin
        ramp_on    = 1'b0;
        drive_duty = saturate_speed(c.speed_value);
      end
      OP_SET_DIR: begin
        ramp_on = 1'b0;
        if (!c.speed_value[15]) drive_duty = saturate_speed(c.speed_value);
        case (c.direction)
          DIR_FWD: begin
            drive_fwd = 1'b1; drive_en = 1'b1; drive_brake = 1'b0;
          end
          DIR_REV: begin
            drive_fwd = 1'b0; drive_en = 1'b1; drive_brake = 1'b0;
          end
          DIR_BRAKE: begin
            drive_en = 1'b0; drive_brake = 1'b1; drive_duty = 8'd0;
          end
          default: begin
            drive_en = 1'b0; drive_brake = 1'b0; drive_duty = 8'd0;
          end
        endcase
      end
      OP_RAMP: begin
        ramp_on = 1'b0;
        nsteps  = (cfg_period != 0) ? c.ramp_duration / cfg_period : 16'd0;
        if (c.ramp_duration == 0 || nsteps == 0) begin
          drive_duty = c.ramp_target;
        end else begin
          ramp_from = drive_duty;
          ramp_to   = c.ramp_target;
          ramp_len  = nsteps;
          ramp_pos  = '0;
          ms_count  = '0;
          ramp_on   = 1'b1;
        end
      end
      default: begin
        // tick: only matters while a ramp runs
        if (ramp_on) begin
          ms_count = ms_count + 8'd1;
          if (ms_count >= cfg_period) begin
            ms_count = '0;
            ramp_pos = ramp_pos + 16'd1;
            if (ramp_pos >= ramp_len) begin
              drive_duty = ramp_to;
              ramp_on    = 1'b0;
            end else begin
              // floor division, rounding toward minus infinity
              diff = int'(ramp_to) - int'(ramp_from);
              prod = diff * int'(ramp_pos);
              den  = int'(ramp_len);
              if (prod >= 0) q = prod / den;
              else q = -((-prod + den - 1) / den);
              drive_duty = 8'(int'(ramp_from) + q);
            end
          end
        end
      end
    endcase
    r.duty         = drive_duty;
    r.forward_line = drive_fwd;
    r.enable_line  = drive_en;
    r.brake_line   = drive_brake;
    r.ramp_busy    = ramp_on;
    r.fault        = cfg_wired & ~c.alarm_level;
    return r;
  endfunction

  function automatic in_t make_cmd(input op_t op, input logic signed [15:0] speed,
                                   input dir_t dir, input logic [7:0] tgt,
                                   input logic [15:0] dur, input logic alarm);
    in_t c;
    c.operation     = op;
    c.speed_value   = speed;
    c.direction     = dir;
    c.ramp_target   = tgt;
    c.ramp_duration = dur;
    c.alarm_level   = alarm;
    return c;
  endfunction

  function automatic out_t make_lines(input logic [7:0] d, input logic f, input logic e,
                                      input logic b, input logic busy, input logic flt);
    out_t r;
    r.duty         = d;
    r.forward_line = f;
    r.enable_line  = e;
    r.brake_line   = b;
    r.ramp_busy    = busy;
    r.fault        = flt;
    return r;
  endfunction

  function automatic test_row_t cmd_row(input in_t c, input int reps);
    test_row_t t;
    t = '{default: '0};
    t.item = c;
    t.reps = reps;
    return t;
  endfunction

  function automatic test_row_t known_row(input in_t c, input out_t r);
    test_row_t t;
    t = cmd_row(c, 1);
    t.has_res = 1'b1;
    t.res     = r;
    return t;
  endfunction

  function automatic test_row_t cfg_row(input logic [7:0] period, input logic alarm_wired);
    test_row_t t;
    t = '{default: '0};
    t.is_cfg      = 1'b1;
    t.period      = period;
    t.alarm_wired = alarm_wired;
    return t;
  endfunction

  function automatic in_t random_command();
    return make_cmd(op_t'($urandom_range(0, 3)), 16'($urandom), dir_t'($urandom_range(0, 3)),
                    8'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  function automatic logic signed [15:0] pick_speed();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($urandom_range(0, 300));
    if (sel < 7) return 16'($urandom);
    if (sel < 8) return -16'sd1 - 16'($urandom_range(0, 300));
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'shFFFF;
      3: return 16'sd255;
      default: return 16'sd256;
    endcase
  endfunction

  // Sender gap: mostly none, some short, a few long, and runs with no gaps at all
  function automatic int pick_gap();
    int sel;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_items = 40;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Offer one input transaction, wait for it to be taken, and queue its expected result.
  task automatic send_command(input in_t c, input bit known, input out_t known_res);
    out_t predicted;
    int   gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    predicted = apply_command(c);
    expected_lines.push_back(known ? known_res : predicted);
  endtask

  task automatic send_tick();
    in_t c;
    c = random_command();
    c.operation = OP_TICK;
    send_command(c, 1'b0, '0);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input logic [7:0] period, input logic alarm_wired);
    cfg_index    <= REG_STEP_PERIOD;
    cfg_data     <= period;
    cfg_write_en <= 1'b1;
    @(posedge clk);
    cfg_period    = period;
    cfg_index    <= REG_ALARM_CONN;
    cfg_data     <= {{(CFG_W-1){1'b0}}, alarm_wired};
    @(posedge clk);
    cfg_wired     = alarm_wired;
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // A ramp start followed by the ticks to run it, sometimes cut short.
  task automatic ramp_burst();
    in_t c;
    int  period;
    int  steps_want;
    int  dur;
    int  n_ticks;
    period = cfg_period;
    if (period == 0) begin
      dur     = $urandom_range(1, 3000);
      n_ticks = $urandom_range(0, 2);
    end else begin
      steps_want = $urandom_range(1, (period > 60) ? 2 : 8);
      dur        = period * steps_want + $urandom_range(0, period - 1);
      n_ticks    = period * steps_want + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        dur     = $urandom_range(0, 65535);
        n_ticks = $urandom_range(0, 40);
      end
      if ($urandom_range(0, 3) == 0) n_ticks = $urandom_range(0, n_ticks);
    end
    // keep the burst inside the item budget of the phase
    if (n_ticks > phase_end - sent_items - 1) n_ticks = phase_end - sent_items - 1;
    if (n_ticks < 0) n_ticks = 0;
    c = random_command();
    c.operation     = OP_RAMP;
    c.ramp_duration = 16'(dur);
    send_command(c, 1'b0, '0);
    repeat (n_ticks) send_tick();
  endtask

  // Result sink: random ready pattern, plus one long hold-off on request
  initial begin : result_sink
    int  run;
    bit  level;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 0;
        out_ready  <= 1'b0;
        run         = 400;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        run        = $urandom_range(50, 200);
      end else begin
        level      = ($urandom_range(0, 3) != 0);
        out_ready <= level;
        if (level) run = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0) run = $urandom_range(10, 40);
        else run = $urandom_range(1, 3);
      end
      repeat (run) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare every result transaction with the oldest expectation
  initial begin : result_check
    out_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          $error("result transaction with no expectation pending");
          error_count++;
        end else begin
          want = expected_lines.pop_front();
          check_field("duty", want.duty, out_data.duty);
          check_field("forward_line", want.forward_line, out_data.forward_line);
          check_field("enable_line", want.enable_line, out_data.enable_line);
          check_field("brake_line", want.brake_line, out_data.brake_line);
          check_field("ramp_busy", want.ramp_busy, out_data.ramp_busy);
          check_field("fault", want.fault, out_data.fault);
        end
      end
    end
  end

  initial begin : stimulus
    test_row_t   directed_table[];
    logic [7:0]  phase_period[7];
    logic        phase_wired[7];
    int          sel;
    in_t         c;

    // state after reset
    drive_duty  = '0;
    drive_fwd   = 1'b0;
    drive_en    = 1'b0;
    drive_brake = 1'b1;
    ramp_on     = 1'b0;
    ramp_from   = '0;
    ramp_to     = '0;
    ramp_len    = '0;
    ramp_pos    = '0;
    ms_count    = '0;
    cfg_period  = STEP_PERIOD_RESET;
    cfg_wired   = 1'b0;

    directed_table = {
      // reset values, idle tick
      known_row(make_cmd(OP_TICK, 16'sd0, DIR_FWD, 8'd0, 16'd0, 1'b0),
                make_lines(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)),
      // speed clamps at both ends
      known_row(make_cmd(OP_SET_SPEED, 16'sh7FFF, DIR_FWD, 8'd0, 16'd0, 1'b0),
                make_lines(8'd255, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)),
      known_row(make_cmd(OP_SET_SPEED, 16'sh8000, DIR_FWD, 8'd0, 16'd0, 1'b0),
                make_lines(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)),
      known_row(make_cmd(OP_SET_DIR, 16'sd100, DIR_FWD, 8'd0, 16'd0, 1'b1),
                make_lines(8'd100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)),
      // negative speed leaves duty alone on a direction change
      known_row(make_cmd(OP_SET_DIR, 16'shFFFF, DIR_REV, 8'd0, 16'd0, 1'b0),
                make_lines(8'd100, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)),
      known_row(make_cmd(OP_SET_DIR, 16'sd200, DIR_BRAKE, 8'd0, 16'd0, 1'b0),
                make_lines(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)),
      known_row(make_cmd(OP_SET_DIR, 16'sd0, DIR_FWD, 8'd0, 16'd0, 1'b0),
                make_lines(8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)),
      // zero duration and zero step count both jump
      known_row(make_cmd(OP_RAMP, 16'sd0, DIR_FWD, 8'd255, 16'd0, 1'b0),
                make_lines(8'd255, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)),
      known_row(make_cmd(OP_RAMP, 16'sd0, DIR_FWD, 8'd0, 16'd9, 1'b0),
                make_lines(8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)),
      known_row(make_cmd(OP_RAMP, 16'sd0, DIR_FWD, 8'd200, 16'd30, 1'b0),
                make_lines(8'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0)),
      cmd_row(make_cmd(OP_TICK, 16'sd0, DIR_FWD, 8'd0, 16'd0, 1'b0), 30),
      // alarm wired, longest ramp, then period zero under a running ramp
      cfg_row(8'd1, 1'b1),
      cmd_row(make_cmd(OP_RAMP, 16'sd0, DIR_REV, 8'd0, 16'hFFFF, 1'b0), 1),
      cmd_row(make_cmd(OP_TICK, 16'sd0, DIR_FWD, 8'd0, 16'd0, 1'b1), 5),
      cfg_row(8'd0, 1'b1),
      cmd_row(make_cmd(OP_TICK, 16'sd0, DIR_FWD, 8'd0, 16'd0, 1'b0), 4),
      cmd_row(make_cmd(OP_RAMP, 16'sd0, DIR_FWD, 8'd77, 16'd500, 1'b1), 1),
      // widest period, falling ramp with rounding down
      cfg_row(8'd255, 1'b0),
      cmd_row(make_cmd(OP_RAMP, 16'sd0, DIR_FWD, 8'd0, 16'd510, 1'b0), 1),
      cmd_row(make_cmd(OP_TICK, 16'sd0, DIR_FWD, 8'd0, 16'd0, 1'b0), 300),
      cmd_row(make_cmd(OP_SET_SPEED, 16'sd256, DIR_FWD, 8'd0, 16'd0, 1'b0), 1),
      cmd_row(make_cmd(OP_RAMP, 16'sd0, DIR_FWD, 8'd10, 16'hFFFF, 1'b0), 1),
      cmd_row(make_cmd(OP_TICK, 16'sd0, DIR_FWD, 8'd0, 16'd0, 1'b0), 3),
      // coast cancels the ramp and keeps the forward line
      cmd_row(make_cmd(OP_SET_DIR, 16'sd50, DIR_COAST, 8'd0, 16'd0, 1'b0), 1),
      cmd_row(make_cmd(OP_SET_DIR, 16'sd300, DIR_REV, 8'd0, 16'd0, 1'b0), 1)
    };

    phase_period = '{8'd10, 8'd1, 8'd255, 8'd3, 8'd0, 8'($urandom_range(1, 255)), 8'd2};
    phase_wired  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'($urandom), 1'b0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_table[i]) begin
      if (directed_table[i].is_cfg) begin
        drain();
        write_settings(directed_table[i].period, directed_table[i].alarm_wired);
      end else begin
        repeat (directed_table[i].reps)
          send_command(directed_table[i].item, directed_table[i].has_res, directed_table[i].res);
      end
    end

    // random phases, one setting each, sharing what is left of the item budget
    for (int p = 0; p < 7; p++) begin
      drain();
      write_settings(phase_period[p], phase_wired[p]);
      if (p == 1) rx_hold_req = 1;
      phase_end = sent_items + (ITEMS_GOAL - sent_items) / (7 - p);
      // a ramp left over from the last phase now runs under the new period
      if (ramp_on) repeat ($urandom_range(1, 20)) send_tick();
      while (sent_items < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          ramp_burst();
        end else if (sel < 80) begin
          c = random_command();
          c.operation   = $urandom_range(0, 1) ? OP_SET_SPEED : OP_SET_DIR;
          c.speed_value = pick_speed();
          send_command(c, 1'b0, '0);
        end else if (sel < 90) begin
          c = random_command();
          c.operation     = OP_RAMP;
          c.ramp_duration = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, cfg_period));
          send_command(c, 1'b0, '0);
        end else begin
          send_command(random_command(), 1'b0, '0);
        end
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("motor_drive_ramp_controller_tb: PASS");
    end else begin
      $display("motor_drive_ramp_controller_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mdrc_pkg.sv
hw/rtl/mdrc_div.sv
hw/rtl/mdrc_datapath.sv
hw/rtl/mdrc_ctrl.sv
hw/rtl/motor_drive_ramp_controller.sv
hw/rtl/mdrc_chk.sv
dv/motor_drive_ramp_controller_tb.sv
